### sv/vec3_pkg.sv
package vec3_pkg;

    // operation codes
    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_NEG       = 4'd2;
    localparam logic [3:0] OP_SCALE     = 4'd3;
    localparam logic [3:0] OP_DOT       = 4'd4;
    localparam logic [3:0] OP_CROSS     = 4'd5;
    localparam logic [3:0] OP_NORM2     = 4'd6;
    localparam logic [3:0] OP_NORM      = 4'd7;
    localparam logic [3:0] OP_NORMALIZE = 4'd8;
    localparam logic [3:0] OP_EQUAL     = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_XDIM = 2'd3;

    // configuration register indexes
    localparam logic CFG_DIM = 1'b0;
    localparam logic CFG_TOL = 1'b1;

    // square root steps, one result bit each
    localparam int SQ_STEPS = 32;

    localparam logic signed [66:0] SAT_MAX = 67'sh7FFF_FFFF;
    localparam logic signed [66:0] SAT_MIN = -67'sh8000_0000;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } req_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_scalar;
        logic               is_equal;
        logic [1:0]         status;
    } rsp_t;

    // per-lane products and elementwise results
    typedef struct packed {
        logic signed [31:0] vec;
        logic               vsat;
        logic               eq;
        logic signed [63:0] p;
        logic signed [63:0] q;
        logic [31:0]        mag;
        logic               neg;
    } lane_t;

    // merged result carried alongside the root and divide pipelines
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] vec;
        logic [31:0]      scalar;
        logic             eq;
        logic             sat;
        logic [1:0]       err;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } side_t;

    // saturate to 32 bits, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [66:0] v);
        logic [32:0] res;
        if (v > SAT_MAX)
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < SAT_MIN)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

### sv/vector3_alu.sv
// vector3_alu: three-lane fixed-point vector unit
// req channel: req_valid / req_stall / req_data carry one operation per beat
// (op, operands a and b, scale factor). rsp channel: rsp_valid / rsp_stall /
// rsp_data return one result beat per request, in order.
// cfg port: cfg_we writes cfg_wdata to register cfg_index (0 lane count,
// 1 equality tolerance); write only while no beat is in flight.
// every op takes the same path through the pipeline. the depth is set by
// the 32-stage square root followed by the per-lane restoring divider,
// one quotient bit per stage.
// throughput: one beat per cycle. every stage holds a valid bit and moves
// when the stage ahead is empty or moving, so bubbles close up.
// when rsp_stall holds the output, the beat waits in the output register
// and upstream keeps accepting until the pipeline is full; only then is
// req_stall raised.
// reset: clears all valid bits and sets lane count 3, tolerance 0.
module vector3_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  vec3_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output vec3_pkg::rsp_t rsp_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_wdata
);

    localparam int QW     = FRAC_BITS + 33;
    localparam int K_LANE = 1;
    localparam int K_MRG  = 2;
    localparam int K_SQ0  = 3;
    localparam int K_PREP = K_SQ0 + vec3_pkg::SQ_STEPS;
    localparam int K_OUT  = K_PREP + QW + 1;
    localparam int NST    = K_OUT + 1;
    localparam int NSIDE  = K_OUT - K_SQ0;
    localparam int J_PREP = K_PREP - K_SQ0;
    localparam logic [QW-1:0] Q_POS_MAX = QW'(64'h7FFF_FFFF);
    localparam logic [QW-1:0] Q_NEG_MAX = QW'(64'h8000_0000);

    logic [1:0]            dim_reg;
    logic [15:0]           tol_reg;
    logic [NST-1:0]        v_reg;
    logic [NST-1:0]        v_next;
    logic [NST-1:0]        en;
    vec3_pkg::req_t        in_reg;
    vec3_pkg::req_t        in_next;
    logic                  xok0_reg;
    logic [1:0]            dim_eff;
    logic [3:0]            op1_reg;
    logic                  xok1_reg;
    logic signed [31:0]    av [3];
    logic signed [31:0]    bv [3];
    vec3_pkg::lane_t [2:0] lanes;
    vec3_pkg::side_t       mrg_side;
    logic [63:0]           ss;
    logic [32:0]           root;
    logic [32:0]           nsat;
    vec3_pkg::side_t       sp_reg [NSIDE];
    vec3_pkg::side_t       sp_in  [NSIDE];
    logic [QW-1:0]         quo [3];
    vec3_pkg::side_t       last;
    vec3_pkg::rsp_t        out_reg;
    vec3_pkg::rsp_t        out_next;
    logic [2:0][31:0]      nv;
    logic [2:0]            nvsat;
    logic                  sat_all;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 2'd3;
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vec3_pkg::CFG_DIM: dim_reg <= cfg_wdata[1:0];
                vec3_pkg::CFG_TOL: tol_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // stage advance: move when empty or when the next stage moves
    for (genvar k = 0; k < NST; k++)
    begin : g_en
        if (k == NST - 1)
        begin : g_tail
            assign en[k] = !v_reg[k] || !rsp_stall;
        end
        else
        begin : g_body
            assign en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_next = {v_reg[NST-2:0], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    assign req_stall = !en[0];
    assign rsp_valid = v_reg[K_OUT];

    // input capture with unused lanes zeroed
    always_comb
    begin
        dim_eff = (dim_reg == 2'd0) ? 2'd1 : dim_reg;
        in_next = req_data;
        if (dim_eff < 2'd2)
        begin
            in_next.a_y = '0;
            in_next.b_y = '0;
        end
        if (dim_eff < 2'd3)
        begin
            in_next.a_z = '0;
            in_next.b_z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            in_reg   <= in_next;
            xok0_reg <= (dim_eff == 2'd3);
        end
        if (en[K_LANE])
        begin
            op1_reg  <= in_reg.op;
            xok1_reg <= xok0_reg;
        end
    end

    assign av[0] = in_reg.a_x;
    assign av[1] = in_reg.a_y;
    assign av[2] = in_reg.a_z;
    assign bv[0] = in_reg.b_x;
    assign bv[1] = in_reg.b_y;
    assign bv[2] = in_reg.b_z;

    // lanes: products and elementwise ops
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vec3_lane u_lane (
            .clk  (clk),
            .en   (en[K_LANE]),
            .op   (in_reg.op),
            .a    (av[i]),
            .b    (bv[i]),
            .k    (in_reg.scale_factor),
            .cu   (av[(i+1)%3]),
            .cv   (bv[(i+2)%3]),
            .cw   (av[(i+2)%3]),
            .cz   (bv[(i+1)%3]),
            .tol  (tol_reg),
            .lane (lanes[i])
        );
    end

    vec3_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk   (clk),
        .en    (en[K_MRG]),
        .op    (op1_reg),
        .xok   (xok1_reg),
        .lanes (lanes),
        .side  (mrg_side),
        .ss    (ss)
    );

    vec3_sqrt u_sqrt (
        .clk  (clk),
        .en   (en[K_PREP-1:K_SQ0]),
        .ss   (ss),
        .root (root)
    );

    assign nsat = vec3_pkg::sat32(67'(root));

    // merged results ride along the root and divide stages
    for (genvar j = 0; j < NSIDE; j++)
    begin : g_side
        if (j == 0)
        begin : g_first
            assign sp_in[j] = mrg_side;
        end
        else if (j == J_PREP)
        begin : g_norm
            always_comb
            begin
                sp_in[j] = sp_reg[j-1];
                if (sp_reg[j-1].op == vec3_pkg::OP_NORM)
                begin
                    sp_in[j].scalar = nsat[31:0];
                    sp_in[j].sat    = nsat[32];
                end
            end
        end
        else
        begin : g_pass
            assign sp_in[j] = sp_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[K_SQ0+j])
            begin
                sp_reg[j] <= sp_in[j];
            end
        end
    end

    // per-lane dividers for normalize
    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vec3_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en[K_OUT-1:K_PREP]),
            .mag (sp_reg[J_PREP-1].mag[i]),
            .n   (root),
            .q   (quo[i])
        );
    end

    assign last = sp_reg[NSIDE-1];

    // signed, saturated normalize lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (last.neg[i])
            begin
                nvsat[i] = (quo[i] > Q_NEG_MAX);
                nv[i]    = nvsat[i] ? 32'h8000_0000 : (~quo[i][31:0] + 32'd1);
            end
            else
            begin
                nvsat[i] = (quo[i] > Q_POS_MAX);
                nv[i]    = nvsat[i] ? 32'h7FFF_FFFF : quo[i][31:0];
            end
        end
    end

    // output beat assembly
    always_comb
    begin
        out_next.r_x      = last.vec[0];
        out_next.r_y      = last.vec[1];
        out_next.r_z      = last.vec[2];
        out_next.r_scalar = last.scalar;
        out_next.is_equal = last.eq;
        sat_all           = last.sat;
        if (last.op == vec3_pkg::OP_NORMALIZE && last.err == vec3_pkg::ST_OK)
        begin
            out_next.r_x = nv[0];
            out_next.r_y = nv[1];
            out_next.r_z = nv[2];
            sat_all      = |nvsat;
        end
        if (last.err != vec3_pkg::ST_OK)
        begin
            out_next.status = last.err;
        end
        else
        begin
            out_next.status = sat_all ? vec3_pkg::ST_SAT : vec3_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[K_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_data = out_reg;

    // zero-vector normalize leaves the vector clear
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == vec3_pkg::ST_ZERO
        |-> rsp_data.r_x == 0 && rsp_data.r_y == 0 && rsp_data.r_z == 0)
        else $error("zero normalize returned nonzero vector");

    // equality beats carry no arithmetic result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.is_equal
        |-> rsp_data.status == vec3_pkg::ST_OK && rsp_data.r_scalar == 0
            && rsp_data.r_x == 0)
        else $error("equal beat with stray result");

    // input held back only when the whole pipe backs up from the output
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> v_reg[K_OUT] && rsp_stall && v_reg[0])
        else $error("req stalled with room in pipeline");

endmodule

### sv/vec3_lane.sv
module vec3_lane (
    input  logic               clk,
    input  logic               en,
    input  logic [3:0]         op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] k,
    input  logic signed [31:0] cu,
    input  logic signed [31:0] cv,
    input  logic signed [31:0] cw,
    input  logic signed [31:0] cz,
    input  logic [15:0]        tol,
    output vec3_pkg::lane_t    lane
);

    vec3_pkg::lane_t    lane_reg;
    vec3_pkg::lane_t    lane_next;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [32:0] ew;
    logic [32:0]        ew_sat;
    logic signed [32:0] diff;
    logic [32:0]        absd;

    // multiplier operand select
    always_comb
    begin
        case (op)
            vec3_pkg::OP_SCALE:
            begin
                mx = a;
                my = k;
            end
            vec3_pkg::OP_CROSS:
            begin
                mx = cu;
                my = cv;
            end
            vec3_pkg::OP_NORM2, vec3_pkg::OP_NORM, vec3_pkg::OP_NORMALIZE:
            begin
                mx = a;
                my = a;
            end
            default:
            begin
                mx = a;
                my = b;
            end
        endcase
    end

    // elementwise add, subtract, negate
    always_comb
    begin
        case (op)
            vec3_pkg::OP_ADD: ew = 33'(a) + 33'(b);
            vec3_pkg::OP_SUB: ew = 33'(a) - 33'(b);
            vec3_pkg::OP_NEG: ew = -33'(a);
            default:          ew = '0;
        endcase
        ew_sat = vec3_pkg::sat32(67'(ew));
    end

    // tolerance compare and lane assembly
    always_comb
    begin
        diff = 33'(a) - 33'(b);
        absd = diff[32] ? 33'(-diff) : 33'(diff);
        lane_next.vec  = ew_sat[31:0];
        lane_next.vsat = ew_sat[32];
        lane_next.eq   = (absd <= {17'd0, tol});
        lane_next.p    = mx * my;
        lane_next.q    = cw * cz;
        lane_next.mag  = a[31] ? (~a + 32'd1) : a;
        lane_next.neg  = a[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

### sv/vec3_merge.sv
module vec3_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [3:0]             op,
    input  logic                   xok,
    input  vec3_pkg::lane_t [2:0]  lanes,
    output vec3_pkg::side_t        side,
    output logic [63:0]            ss
);

    localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

    vec3_pkg::side_t    side_reg;
    vec3_pkg::side_t    side_next;
    logic [63:0]        ss_reg;
    logic signed [66:0] ltot;
    logic [32:0]        tot;
    logic [2:0][32:0]   sc;
    logic [2:0][32:0]   cr;

    function automatic logic signed [66:0] rnd(input logic signed [66:0] v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

    // rounded products and sums
    always_comb
    begin
        ltot = 67'(lanes[0].p) + 67'(lanes[1].p) + 67'(lanes[2].p);
        tot  = vec3_pkg::sat32(rnd(ltot));
        for (int i = 0; i < 3; i++)
        begin
            sc[i] = vec3_pkg::sat32(rnd(67'(lanes[i].p)));
            cr[i] = vec3_pkg::sat32(rnd(67'(lanes[i].p) - 67'(lanes[i].q)));
        end
    end

    // pick results by op
    always_comb
    begin
        side_next.op     = op;
        side_next.vec    = '0;
        side_next.scalar = '0;
        side_next.eq     = 1'b0;
        side_next.sat    = 1'b0;
        side_next.err    = vec3_pkg::ST_OK;
        for (int i = 0; i < 3; i++)
        begin
            side_next.mag[i] = lanes[i].mag;
            side_next.neg[i] = lanes[i].neg;
        end
        case (op)
            vec3_pkg::OP_ADD, vec3_pkg::OP_SUB, vec3_pkg::OP_NEG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    side_next.vec[i] = lanes[i].vec;
                end
                side_next.sat = lanes[0].vsat | lanes[1].vsat | lanes[2].vsat;
            end
            vec3_pkg::OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    side_next.vec[i] = sc[i][31:0];
                end
                side_next.sat = sc[0][32] | sc[1][32] | sc[2][32];
            end
            vec3_pkg::OP_DOT, vec3_pkg::OP_NORM2:
            begin
                side_next.scalar = tot[31:0];
                side_next.sat    = tot[32];
            end
            vec3_pkg::OP_CROSS:
            begin
                if (!xok)
                begin
                    side_next.err = vec3_pkg::ST_XDIM;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        side_next.vec[i] = cr[i][31:0];
                    end
                    side_next.sat = cr[0][32] | cr[1][32] | cr[2][32];
                end
            end
            vec3_pkg::OP_NORMALIZE:
            begin
                if (ltot == '0)
                begin
                    side_next.err = vec3_pkg::ST_ZERO;
                end
            end
            vec3_pkg::OP_EQUAL:
            begin
                side_next.eq = lanes[0].eq & lanes[1].eq & lanes[2].eq;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            ss_reg   <= ltot[63:0];
        end
    end

    assign side = side_reg;
    assign ss   = ss_reg;

endmodule

### sv/vec3_sqrt.sv
module vec3_sqrt (
    input  logic                          clk,
    input  logic [vec3_pkg::SQ_STEPS-1:0] en,
    input  logic [63:0]                   ss,
    output logic [32:0]                   root
);

    localparam int LAST = vec3_pkg::SQ_STEPS - 1;

    logic [63:0] x_reg [vec3_pkg::SQ_STEPS];
    logic [63:0] r_reg [vec3_pkg::SQ_STEPS];

    // one result bit per stage
    for (genvar j = 0; j < vec3_pkg::SQ_STEPS; j++)
    begin : g_step
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
        logic [63:0] x_in;
        logic [63:0] r_in;
        logic [64:0] trial;

        if (j == 0)
        begin : g_first
            assign x_in = ss;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        assign trial = {1'b0, r_in} + {1'b0, BITV};

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                if ({1'b0, x_in} >= trial)
                begin
                    x_reg[j] <= x_in - trial[63:0];
                    r_reg[j] <= (r_in >> 1) + BITV;
                end
                else
                begin
                    x_reg[j] <= x_in;
                    r_reg[j] <= r_in >> 1;
                end
            end
        end
    end

    // round to nearest: remainder above root bumps it
    assign root = 33'(r_reg[LAST]) + 33'(x_reg[LAST] > r_reg[LAST]);

endmodule

### sv/vec3_div.sv
module vec3_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic [FRAC_BITS+33:0]   en,
    input  logic [31:0]             mag,
    input  logic [32:0]             n,
    output logic [FRAC_BITS+32:0]   q
);

    localparam int QW = FRAC_BITS + 33;

    logic [QW-1:0] dq_reg  [QW+1];
    logic [32:0]   rem_reg [QW];
    logic [32:0]   n_reg   [QW];

    // rounded dividend: mag scaled up plus half the divisor
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dq_reg[0]  <= (QW'(mag) << FRAC_BITS) + QW'(n >> 1);
            rem_reg[0] <= '0;
            n_reg[0]   <= n;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [33:0] rem_s;
        logic        ge;

        assign rem_s = {rem_reg[j-1], dq_reg[j-1][QW-1]};
        assign ge    = (rem_s >= {1'b0, n_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                dq_reg[j] <= {dq_reg[j-1][QW-2:0], ge};
            end
        end

        if (j < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= ge ? 33'(rem_s - {1'b0, n_reg[j-1]}) : 33'(rem_s);
                    n_reg[j]   <= n_reg[j-1];
                end
            end
        end
    end

    assign q = dq_reg[QW];

endmodule
